// ===== rtl/core/nps_pkg.sv =====
// Package for the nearest pitch slice selector: transaction structs,
// operation codes, table size and the controller state type.
// No dependencies.
package nps_pkg;

  // Table geometry, fixed by the 6-bit entry index
  localparam int unsigned MAX_SLICES = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned PITCH_W    = 32;
  localparam int unsigned RND_W      = 16;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          entry_index;
    logic signed [PITCH_W-1:0] entry_root_pitch;
    logic signed [PITCH_W-1:0] pitch;
    logic [RND_W-1:0]          random_value;
  } nps_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] slice_index;
  } nps_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK
  } nps_state_t;

endpackage

// ===== rtl/core/nearest_pitch_slice_select.sv =====
// Nearest pitch slice selector: root pitch table in a one-port synchronous
// memory, scanned one entry per cycle to choose a slice for a pitch.
// Depends on nps_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   cfg     | in        | cfg_wr_en          | cfg_wr_data (entry_count)
//   in      | in        | in_valid/in_stall  | nps_in_t
//   out     | out       | out_valid/out_stall| nps_out_t
//
// A load transaction leaves the block ready at once.
// A select scans up to N entries before the pick state, N being entry_count
// capped at MAX_SLICES: one table read per cycle from the single memory port,
// then the random pick, which waits while out_stall holds the last result.
// Reset (rst_n low, synchronous) clears the controller, the output valid and
// entry_count and holds in_stall high; the table memory is not cleared.
// A finished result waits in the output register under out_stall; the next
// transaction is taken meanwhile, and a second result waits in the pick cycle.
module nearest_pitch_slice_select (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [nps_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nps_pkg::nps_in_t                 in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nps_pkg::nps_out_t                out_item
);
  import nps_pkg::*;

  // Root pitch table
  logic signed [PITCH_W-1:0] mem [MAX_SLICES];
  logic signed [PITCH_W-1:0] rd_data_r;
  logic [IDX_W-1:0]          rd_addr;

  // Control and working registers
  nps_state_t                state_r, state_nxt;
  logic [CNT_W-1:0]          entry_count_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          start_r, start_nxt;
  logic [CNT_W-1:0]          end_r, end_nxt;
  logic signed [PITCH_W-1:0] cur_r, cur_nxt;
  logic signed [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic [RND_W-1:0]          rnd_r, rnd_nxt;
  logic                      first_r, first_nxt;
  logic                      extend_r, extend_nxt;
  logic                      empty_r, empty_nxt;
  logic                      out_valid_r, out_valid_nxt;
  nps_out_t                  out_item_r, out_item_nxt;

  logic                      in_acc;
  logic                      load_acc;
  logic [CNT_W-1:0]          cnt_clamped;
  logic signed [PITCH_W:0]   below;
  logic signed [PITCH_W:0]   above;
  logic [CNT_W-1:0]          size;
  logic [RND_W+CNT_W-1:0]    prod;
  logic [CNT_W-1:0]          sel;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_item.operation == OP_LOAD);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Counts above the table size read as the table size
  assign cnt_clamped = (entry_count_r > CNT_W'(MAX_SLICES)) ? CNT_W'(MAX_SLICES)
                                                             : entry_count_r;

  // Distances to the previous group and to the current entry, exact in 33 bits
  assign below = {pitch_r[PITCH_W-1], pitch_r} - {cur_r[PITCH_W-1], cur_r};
  assign above = {rd_data_r[PITCH_W-1], rd_data_r} - {pitch_r[PITCH_W-1], pitch_r};

  // Pick inside the group: start + (random * size) >> 16
  assign size = end_r - start_r;
  assign prod = (RND_W+CNT_W)'(rnd_r) * (RND_W+CNT_W)'(size);
  assign sel  = start_r + prod[RND_W +: CNT_W];

  // Table memory: write on load, read every cycle
  always_ff @(posedge clk) begin
    if (load_acc) begin
      mem[in_item.entry_index] <= in_item.entry_root_pitch;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr_en) begin
      entry_count_r <= cfg_wr_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    cur_r      <= cur_nxt;
    pitch_r    <= pitch_nxt;
    rnd_r      <= rnd_nxt;
    first_r    <= first_nxt;
    extend_r   <= extend_nxt;
    empty_r    <= empty_nxt;
    out_item_r <= out_item_nxt;
  end

  // Next state: scan the table in order, then pick
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    cur_nxt       = cur_r;
    pitch_nxt     = pitch_r;
    rnd_nxt       = rnd_r;
    first_nxt     = first_r;
    extend_nxt    = extend_r;
    empty_nxt     = empty_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_item.operation == OP_SELECT)) begin
          pitch_nxt  = in_item.pitch;
          rnd_nxt    = in_item.random_value;
          cnt_nxt    = cnt_clamped;
          idx_nxt    = '0;
          start_nxt  = '0;
          end_nxt    = '0;
          first_nxt  = 1'b1;
          extend_nxt = 1'b0;
          empty_nxt  = (cnt_clamped == '0);
          state_nxt  = (cnt_clamped == '0) ? ST_PICK : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // rd_data_r holds entry idx_r; fetch the following one
        rd_addr = IDX_W'(idx_r + CNT_W'(1));
        idx_nxt = idx_r + CNT_W'(1);
        priority if (idx_r == cnt_r) begin
          end_nxt   = idx_r;
          state_nxt = ST_PICK;
        end else if (extend_r) begin
          // Extend the upper group while roots stay equal
          if (rd_data_r != cur_r) begin
            end_nxt   = idx_r;
            state_nxt = ST_PICK;
          end
        end else if (first_r) begin
          cur_nxt   = rd_data_r;
          first_nxt = 1'b0;
        end else if ((rd_data_r != cur_r) && (pitch_r <= rd_data_r)) begin
          // Straddling pair found; ties keep the lower group
          if (below > above) begin
            start_nxt  = idx_r;
            cur_nxt    = rd_data_r;
            extend_nxt = 1'b1;
          end else begin
            end_nxt   = idx_r;
            state_nxt = ST_PICK;
          end
        end else if (rd_data_r != cur_r) begin
          cur_nxt   = rd_data_r;
          start_nxt = idx_r;
        end
      end

      ST_PICK: begin
        // Wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_item_nxt.found       = !empty_r;
          out_item_nxt.slice_index = IDX_W'(sel);
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/nps_checker.sv =====
// Port-level checks for the nearest pitch slice selector, bound to the top.
// Depends on nps_pkg and nearest_pitch_slice_select.
module nps_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input nps_pkg::nps_in_t          in_item,
  input logic                      out_valid,
  input logic                      out_stall,
  input nps_pkg::nps_out_t         out_item
);
  import nps_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // A select transaction makes the block busy
  a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.operation == OP_SELECT) |=> in_stall)
    else $error("select did not occupy the block");

  // A load transaction leaves the block ready for the next transaction
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.operation == OP_LOAD) |=> !in_stall)
    else $error("load left the block busy");

  // An empty table reports index zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.slice_index == '0)
    else $error("not-found result with non-zero index");

endmodule

bind nearest_pitch_slice_select nps_checker u_nps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== test/nearest_pitch_slice_select_tb.sv =====
// Self-checking testbench for nearest_pitch_slice_select: directed and random
// load/select transactions under random idling and stalls, checked in order.
// Depends on nps_pkg and the nearest_pitch_slice_select RTL.
module nearest_pitch_slice_select_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  localparam int     SETTLE_CYCLES  = MAX_SLICES + 8;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     ITEM_TARGET    = 1020;
  localparam longint PITCH_MAX      = 64'sh7FFF_FFFF;
  localparam longint PITCH_MIN      = -64'sh8000_0000;

  // Shadow of the slice table plus the queue of pending selections
  class slice_scoreboard;
    int                 root_tbl[MAX_SLICES];
    logic [CNT_W-1:0]   entry_count;
    nps_out_t           pending_q[$];
    int                 errors;

    function new();
      foreach (root_tbl[i]) root_tbl[i] = 0;
      entry_count = '0;
      errors      = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Index inside a group of equal roots, chosen by the random fraction
    function logic [IDX_W-1:0] group_pick(int start, int stop, logic [RND_W-1:0] rnd);
      longint offset;
      offset = (longint'(rnd) * longint'(stop - start)) >>> 16;
      return IDX_W'(longint'(start) + offset);
    endfunction

    // In-order scan for the first new root at or above the pitch
    function logic [IDX_W-1:0] nearest_slice(int p, logic [RND_W-1:0] rnd, int count);
      int     cur;
      int     r;
      int     start;
      int     stop;
      longint below;
      longint above;
      cur   = root_tbl[0];
      start = 0;
      for (int i = 0; i < count; i++) begin
        r = root_tbl[i];
        if (r != cur) begin
          if (p <= r) begin
            below = longint'(p) - longint'(cur);
            above = longint'(r) - longint'(p);
            stop  = i;
            // ties stay with the lower group
            if (below > above) begin
              start = i;
              while (stop < count && root_tbl[stop] == r) stop++;
            end
            return group_pick(start, stop, rnd);
          end
          cur   = r;
          start = i;
        end
      end
      // above every root: last group
      return group_pick(start, count, rnd);
    endfunction

    // Accepted input transaction: update the table or queue a selection
    function void note_input(nps_in_t item);
      nps_out_t res;
      int       count;
      if (item.operation == OP_LOAD) begin
        root_tbl[item.entry_index] = item.entry_root_pitch;
      end else begin
        count = (entry_count > MAX_SLICES) ? MAX_SLICES : int'(entry_count);
        if (count == 0) begin
          res.found       = 1'b0;
          res.slice_index = '0;
        end else begin
          res.found       = 1'b1;
          res.slice_index = nearest_slice(item.pitch, item.random_value, count);
        end
        pending_q.push_back(res);
      end
    endfunction

    // Accepted result transaction against the oldest pending selection
    function void check_result(nps_out_t got);
      nps_out_t exp;
      if (pending_q.size() == 0) begin
        $error("unexpected result: found=%0d slice_index=%0d", got.found, got.slice_index);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        errors++;
      end
      if (got.slice_index !== exp.slice_index) begin
        $error("slice_index: expected %0d, got %0d", exp.slice_index, got.slice_index);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CNT_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  nps_in_t             in_item;
  logic                out_valid;
  logic                out_stall;
  nps_out_t            out_item;

  slice_scoreboard     sb = new();
  int                  gen_tbl[MAX_SLICES];
  int                  burst_left = 0;
  int                  item_count = 0;
  int                  stall_mode = 0;
  int                  stall_tick = 0;
  int                  idle_cycles = 0;

  nearest_pitch_slice_select dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  function automatic longint rand_between(input longint lo, input longint hi);
    bit [63:0] r;
    longint    span;
    r    = {$urandom, $urandom};
    span = hi - lo + 1;
    return lo + longint'(r % 64'(span));
  endfunction

  function automatic int clamp32(input longint v);
    if (v > PITCH_MAX) return int'(PITCH_MAX);
    if (v < PITCH_MIN) return int'(PITCH_MIN);
    return int'(v);
  endfunction

  function automatic nps_in_t make_load(input int idx, input int root);
    nps_in_t item;
    item.operation        = OP_LOAD;
    item.entry_index      = IDX_W'(idx);
    item.entry_root_pitch = root;
    item.pitch            = $urandom;
    item.random_value     = RND_W'($urandom);
    return item;
  endfunction

  function automatic nps_in_t make_select(input int p, input logic [RND_W-1:0] rnd);
    nps_in_t item;
    item.operation        = OP_SELECT;
    item.entry_index      = IDX_W'($urandom);
    item.entry_root_pitch = $urandom;
    item.pitch            = p;
    item.random_value     = rnd;
    return item;
  endfunction

  // Random fraction with the end points favoured
  function automatic logic [RND_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return RND_W'($urandom);
    endcase
  endfunction

  // Pitch near the loaded roots: exact, close, midpoint, outside, anywhere, or between two roots
  function automatic int pick_pitch(input int n);
    int     k;
    longint lo;
    longint hi;
    longint p;
    k  = $urandom_range(0, n - 1);
    lo = gen_tbl[k];
    hi = (k < n - 1) ? longint'(gen_tbl[k + 1]) : lo + 64'sd65536;
    case ($urandom_range(0, 9))
      0: p = lo;
      1: p = lo + longint'($urandom_range(0, 6)) - 3;
      2: p = ((lo + hi) >>> 1) + longint'($urandom_range(0, 1));
      3: p = longint'(gen_tbl[0]) - longint'($urandom_range(1, 32'h2_0000));
      4: p = longint'(gen_tbl[n - 1]) + longint'($urandom_range(1, 32'h2_0000));
      5: p = longint'(int'($urandom));
      default: p = (lo < hi) ? rand_between(lo, hi) : rand_between(hi, lo);
    endcase
    return clamp32(p);
  endfunction

  // Sender: bursts of transactions separated by random gaps
  task automatic send_item(input nps_in_t item);
    int gap;
    int pick;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      pick = $urandom_range(0, 9);
      if (pick < 5)      gap = $urandom_range(1, 3);
      else if (pick < 8) gap = $urandom_range(4, 20);
      else               gap = $urandom_range(21, 80);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_input(item);
    item_count++;
  endtask

  // Register write once everything has drained and the block has settled
  task automatic write_entry_count(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    sb.entry_count  = value;
    burst_left      = 0;
  endtask

  // Fill entries 0..n-1, ascending unless scrambled
  task automatic load_table(input int n, input bit scrambled);
    longint      v;
    int unsigned step;
    int          mode;
    mode = $urandom_range(0, 2);
    case (mode)
      0: begin
        v    = rand_between(-64'sh10_0000, 64'sh10_0000);
        step = 32'h8000;
      end
      1: begin
        v    = rand_between(PITCH_MIN, 0);
        step = 32'h0100_0000;
      end
      default: begin
        v    = PITCH_MIN;
        step = 32'hFFFF_FFFF / n;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      if (scrambled) begin
        gen_tbl[k] = ($urandom_range(0, 1) != 0) ? int'($urandom)
                                                : (int'($urandom_range(0, 7)) - 4) * 32'sh1_0000;
      end else begin
        // roughly one in four entries repeats its neighbour to form a group
        if (k > 0 && $urandom_range(0, 3) != 0) v += longint'($urandom_range(1, step));
        if (v > PITCH_MAX) v = PITCH_MAX;
        gen_tbl[k] = int'(v);
        if (mode == 2 && k == n - 1 && $urandom_range(0, 1) != 0) gen_tbl[k] = int'(PITCH_MAX);
      end
      send_item(make_load(k, gen_tbl[k]));
    end
  endtask

  // Receiver: check results and stall under one of four patterns picked at random on stall_tick
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_item);
    stall_tick++;
    if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) != 0);
      2: if ($urandom_range(0, 7) == 0) out_stall <= !out_stall;
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    int count;
    int nsel;
    int phase;
    int k;
    int r;
    int count_plan[6];
    bit scrambled;
    longint lo;
    longint hi;

    count_plan  = '{64, 127, 65, 1, 2, 0};
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    out_stall   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table reports not found
    write_entry_count(CNT_W'(0));
    send_item(make_select(32'sh7FFF_FFFF, 16'hFFFF));

    // Extremes of the pitch range around a group of two
    write_entry_count(CNT_W'(4));
    send_item(make_load(0, 32'sh8000_0000));
    send_item(make_load(1, -32'sh1_0000));
    send_item(make_load(2, -32'sh1_0000));
    send_item(make_load(3, 32'sh7FFF_FFFF));
    send_item(make_select(32'sh8000_0000, 16'h0000));
    send_item(make_select(32'sh7FFF_FFFF, 16'hFFFF));
    send_item(make_select(-32'sh1_0000, 16'hFFFF));
    send_item(make_select(0, 16'h0000));

    // Tie between groups, below every root, above every root
    write_entry_count(CNT_W'(3));
    send_item(make_load(0, 32'sh1_0000));
    send_item(make_load(1, 32'sh3_0000));
    send_item(make_load(2, 32'sh3_0000));
    send_item(make_select(32'sh2_0000, 16'h0000));
    send_item(make_select(32'sh2_0001, 16'hFFFF));
    send_item(make_select(0, 16'h1234));
    send_item(make_select(32'sh4_0000, 16'h8000));

    // Unsorted table: same scan, no error
    send_item(make_load(1, -32'sh5_0000));
    send_item(make_select(0, 16'h4321));

    // Random phases, each with its own entry count
    phase = 0;
    while (item_count < ITEM_TARGET) begin
      if (phase < 6)                         count = count_plan[phase];
      else if ($urandom_range(0, 5) == 0)    count = MAX_SLICES;
      else                                   count = $urandom_range(1, 127);
      scrambled = (phase == 6) || (phase > 6 && $urandom_range(0, 4) == 0);
      write_entry_count(CNT_W'(count));
      n = (count > MAX_SLICES) ? MAX_SLICES : count;
      load_table(n, scrambled);
      nsel = (n == 0) ? 8 : $urandom_range(30, 70);
      for (int j = 0; j < nsel; j++) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          // noise: any entry, any value
          k          = $urandom_range(0, MAX_SLICES - 1);
          gen_tbl[k] = int'($urandom);
          send_item(make_load(k, gen_tbl[k]));
        end else if (r <= 2 && n > 0) begin
          // rewrite one entry between its neighbours, order kept
          k  = $urandom_range(0, n - 1);
          lo = (k > 0) ? longint'(gen_tbl[k - 1]) : longint'(gen_tbl[k]) - 64'sd65536;
          hi = (k < n - 1) ? longint'(gen_tbl[k + 1]) : longint'(gen_tbl[k]) + 64'sd65536;
          gen_tbl[k] = (lo < hi) ? clamp32(rand_between(lo, hi)) : clamp32(lo);
          send_item(make_load(k, gen_tbl[k]));
        end else if (n > 0) begin
          send_item(make_select(pick_pitch(n), pick_fraction()));
        end else begin
          send_item(make_select(int'($urandom), pick_fraction()));
        end
      end
      phase++;
    end

    // Drain and let the block settle
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
